>>> rtl/core/pdq_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// pdq_pkg
// Shared types and constants of the priority deque: item layouts, op codes,
// result codes and the controller-to-datapath command and status groups.
// ----------------------------------------------------------------------------
package pdq_pkg;

    localparam int DEPTH   = 16;
    localparam int TAG_W   = 32;
    localparam int PRIO_W  = 16;
    localparam int COUNT_W = $clog2(DEPTH + 1);
    localparam int ADDR_W  = $clog2(DEPTH);

    localparam logic [2:0] OP_PUSH_FRONT = 3'd0;
    localparam logic [2:0] OP_PUSH_BACK  = 3'd1;
    localparam logic [2:0] OP_POP_FRONT  = 3'd2;
    localparam logic [2:0] OP_POP_BACK   = 3'd3;
    localparam logic [2:0] OP_CLEAR      = 3'd4;

    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_FULL  = 2'd1;
    localparam logic [1:0] ST_EMPTY = 2'd2;

    typedef struct packed {
        logic [2:0]               op;
        logic [TAG_W-1:0]         tag;
        logic signed [PRIO_W-1:0] priority_req;
    } pdq_req_t;

    typedef struct packed {
        logic [1:0]         status;
        logic [TAG_W-1:0]   popped_tag;
        logic [4:0]         entry_count;
    } pdq_rsp_t;

    typedef enum logic [2:0] {
        ACT_NONE,
        ACT_PUSH,
        ACT_POP_FRONT,
        ACT_POP_BACK,
        ACT_CLEAR
    } pdq_act_t;

    typedef struct packed {
        logic       load;
        logic       exec;
        pdq_act_t   action;
        logic [1:0] status;
    } pdq_cmd_t;

    typedef struct packed {
        logic [2:0] op;
        logic       tag_zero;
        logic       full;
        logic       empty;
    } pdq_stat_t;

endpackage
`default_nettype wire

>>> rtl/core/pdq_ctrl.sv
`default_nettype none
// ----------------------------------------------------------------------------
// pdq_ctrl
// Two-state controller: captures an item, then decodes it against the store
// flags into one datapath action and a result code, and strobes the result.
// ----------------------------------------------------------------------------
module pdq_ctrl (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              start,
    output logic                   busy,
    output logic                   done,
    input  wire pdq_pkg::pdq_stat_t stat,
    output pdq_pkg::pdq_cmd_t      cmd
);

    typedef enum logic [1:0] {
        S_IDLE = 2'b01,
        S_EXEC = 2'b10
    } state_t;

    state_t state_reg, state_next;
    logic   done_reg;

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    state_next = S_EXEC;
                end
            end
            S_EXEC:  state_next = S_IDLE;
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            done_reg  <= (state_reg == S_EXEC);
        end
    end

    // action decode
    always_comb
    begin
        cmd.load   = (state_reg == S_IDLE) && start;
        cmd.exec   = (state_reg == S_EXEC);
        cmd.action = pdq_pkg::ACT_NONE;
        cmd.status = pdq_pkg::ST_OK;
        case (stat.op)
            pdq_pkg::OP_PUSH_FRONT, pdq_pkg::OP_PUSH_BACK:
            begin
                if (!stat.tag_zero)
                begin
                    if (stat.full)
                    begin
                        cmd.status = pdq_pkg::ST_FULL;
                    end
                    else
                    begin
                        cmd.action = pdq_pkg::ACT_PUSH;
                    end
                end
            end
            pdq_pkg::OP_POP_FRONT:
            begin
                if (stat.empty)
                begin
                    cmd.status = pdq_pkg::ST_EMPTY;
                end
                else
                begin
                    cmd.action = pdq_pkg::ACT_POP_FRONT;
                end
            end
            pdq_pkg::OP_POP_BACK:
            begin
                if (stat.empty)
                begin
                    cmd.status = pdq_pkg::ST_EMPTY;
                end
                else
                begin
                    cmd.action = pdq_pkg::ACT_POP_BACK;
                end
            end
            pdq_pkg::OP_CLEAR: cmd.action = pdq_pkg::ACT_CLEAR;
            default:           cmd.action = pdq_pkg::ACT_NONE;
        endcase
    end

    assign busy = (state_reg != S_IDLE);
    assign done = done_reg;

endmodule
`default_nettype wire

>>> rtl/core/pdq_dpath.sv
`default_nettype none
// ----------------------------------------------------------------------------
// pdq_dpath
// Shifting row of tag/priority cells with the entry count. Every cell decides
// locally whether it holds, takes the new entry or takes its neighbor.
// ----------------------------------------------------------------------------
module pdq_dpath (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              cfg_we,
    input  wire logic              cfg_wdata,
    input  wire pdq_pkg::pdq_req_t req,
    input  wire pdq_pkg::pdq_cmd_t cmd,
    output pdq_pkg::pdq_stat_t     stat,
    output pdq_pkg::pdq_rsp_t      rsp
);

    localparam int DEPTH   = pdq_pkg::DEPTH;
    localparam int COUNT_W = pdq_pkg::COUNT_W;
    localparam int ADDR_W  = pdq_pkg::ADDR_W;

    logic                             mode_reg;
    logic [COUNT_W-1:0]               count_reg, count_next;
    pdq_pkg::pdq_req_t                req_reg;
    pdq_pkg::pdq_rsp_t                rsp_reg;

    logic [pdq_pkg::TAG_W-1:0]        tag_reg  [DEPTH];
    logic [pdq_pkg::TAG_W-1:0]        tag_next [DEPTH];
    logic signed [pdq_pkg::PRIO_W-1:0] prio_reg  [DEPTH];
    logic signed [pdq_pkg::PRIO_W-1:0] prio_next [DEPTH];

    logic [DEPTH-1:0]                 keep;
    logic signed [pdq_pkg::PRIO_W-1:0] new_prio;
    logic [ADDR_W-1:0]                last_idx;
    logic [pdq_pkg::TAG_W-1:0]        popped;

    assign stat.op       = req_reg.op;
    assign stat.tag_zero = (req_reg.tag == '0);
    assign stat.full     = (count_reg == COUNT_W'(DEPTH));
    assign stat.empty    = (count_reg == '0);

    assign new_prio = mode_reg ? req_reg.priority_req : '0;
    assign last_idx = ADDR_W'(count_reg - COUNT_W'(1));

    // cells that stay put on a push; always a run from the front, since
    // deque-mode entries can leave the row out of priority order
    always_comb
    begin
        logic run;
        run = 1'b1;
        for (int i = 0; i < DEPTH; i++)
        begin
            if (mode_reg)
            begin
                run = run && (COUNT_W'(i) < count_reg)
                      && (prio_reg[i] >= req_reg.priority_req);
                keep[i] = run;
            end
            else if (req_reg.op == pdq_pkg::OP_PUSH_BACK)
            begin
                keep[i] = (COUNT_W'(i) < count_reg);
            end
            else
            begin
                keep[i] = 1'b0;
            end
        end
    end

    always_comb
    begin
        for (int i = 0; i < DEPTH; i++)
        begin
            tag_next[i]  = tag_reg[i];
            prio_next[i] = prio_reg[i];
        end
        count_next = count_reg;
        popped     = '0;
        case (cmd.action)
            pdq_pkg::ACT_PUSH:
            begin
                if (!keep[0])
                begin
                    tag_next[0]  = req_reg.tag;
                    prio_next[0] = new_prio;
                end
                for (int i = 1; i < DEPTH; i++)
                begin
                    if (!keep[i])
                    begin
                        if (keep[i-1])
                        begin
                            tag_next[i]  = req_reg.tag;
                            prio_next[i] = new_prio;
                        end
                        else
                        begin
                            tag_next[i]  = tag_reg[i-1];
                            prio_next[i] = prio_reg[i-1];
                        end
                    end
                end
                count_next = count_reg + COUNT_W'(1);
            end
            pdq_pkg::ACT_POP_FRONT:
            begin
                popped = tag_reg[0];
                for (int i = 0; i < DEPTH - 1; i++)
                begin
                    tag_next[i]  = tag_reg[i+1];
                    prio_next[i] = prio_reg[i+1];
                end
                count_next = count_reg - COUNT_W'(1);
            end
            pdq_pkg::ACT_POP_BACK:
            begin
                popped     = tag_reg[last_idx];
                count_next = count_reg - COUNT_W'(1);
            end
            pdq_pkg::ACT_CLEAR: count_next = '0;
            default:            count_next = count_reg;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg  <= 1'b0;
            count_reg <= '0;
        end
        else
        begin
            if (cfg_we)
            begin
                mode_reg <= cfg_wdata;
            end
            if (cmd.exec)
            begin
                count_reg <= count_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            req_reg <= req;
        end
        if (cmd.exec)
        begin
            for (int i = 0; i < DEPTH; i++)
            begin
                tag_reg[i]  <= tag_next[i];
                prio_reg[i] <= prio_next[i];
            end
            rsp_reg.status      <= cmd.status;
            rsp_reg.popped_tag  <= popped;
            rsp_reg.entry_count <= 5'(count_next);
        end
    end

    assign rsp = rsp_reg;

endmodule
`default_nettype wire

>>> rtl/core/priority_deque_unit.sv
`default_nettype none
// An accepted item is captured in the idle state and executed in the exec state;
// its result strobes on done for one cycle right after that.
// The controller takes no new item until the current one has executed; the
// cell row inserts or shifts in place within the exec state.
// Reset clears the entry count, the controller and priority mode (deque mode);
// the cell contents are not cleared. The receiver cannot stall results.
// ----------------------------------------------------------------------------
// priority_deque_unit
// Bounded 16-entry queue of tags with signed priorities: ordered insertion
// (FIFO among equals) in priority mode, plain deque otherwise.
// ----------------------------------------------------------------------------
module priority_deque_unit (
    input  wire logic              clk,
    input  wire logic              rst_n,
    // command side: item taken when start && !busy
    input  wire logic              start,
    output logic                   busy,
    input  wire pdq_pkg::pdq_req_t req,
    // result side: one-cycle strobe, no back-pressure
    output logic                   done,
    output pdq_pkg::pdq_rsp_t      rsp,
    // priority_mode register
    input  wire logic              cfg_we,
    input  wire logic              cfg_wdata
);

    pdq_pkg::pdq_cmd_t  cmd;
    pdq_pkg::pdq_stat_t stat;

    // Controller: capture in idle, decode against full/empty and act in exec.
    pdq_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .busy  (busy),
        .done  (done),
        .stat  (stat),
        .cmd   (cmd)
    );

    // Datapath: the cell row, entry count, mode register and result register.
    pdq_dpath u_dpath (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .req       (req),
        .cmd       (cmd),
        .stat      (stat),
        .rsp       (rsp)
    );

    // An accepted item always produces its result strobe once it has executed.
    a_item_result: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |-> ##2 done)
        else $error("accepted item produced no result");

    // Results appear only when the unit is ready for the next item.
    a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> !busy)
        else $error("result strobe while busy");

    // The strobe is a single-cycle pulse.
    a_done_pulse: assert property (@(posedge clk) disable iff (!rst_n)
        done |=> !done)
        else $error("result strobe held over two cycles");

    // Reported count never exceeds the store size.
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> (rsp.entry_count <= 5'(pdq_pkg::DEPTH)))
        else $error("entry count beyond depth");

endmodule
`default_nettype wire

>>> verif/pdq_checker.sv
`default_nettype none
// ----------------------------------------------------------------------------
// pdq_checker
// Watches the command, result and mode-register ports of the priority
// deque. It keeps its own copy of the store, predicts one result per item
// and compares each result strobe with the oldest prediction.
// ----------------------------------------------------------------------------
module pdq_checker (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              start,
    input  wire logic              busy,
    input  wire pdq_pkg::pdq_req_t req,
    input  wire logic              done,
    input  wire pdq_pkg::pdq_rsp_t rsp,
    input  wire logic              cfg_we,
    input  wire logic              cfg_wdata,
    output int                     fail_count,
    output int                     pending_count
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam int REPORT_MAX = 10;

    // Shadow store, front entry at index 0
    logic [pdq_pkg::TAG_W-1:0]         tag_cell  [pdq_pkg::DEPTH];
    logic signed [pdq_pkg::PRIO_W-1:0] prio_cell [pdq_pkg::DEPTH];
    int                                fill         = 0;
    logic                              ordered_mode = 1'b0;

    pdq_pkg::pdq_rsp_t rsp_due_q [$];
    pdq_pkg::pdq_rsp_t want;
    pdq_pkg::pdq_rsp_t predicted;
    int                mismatches = 0;
    int                results_seen = 0;

    assign fail_count    = mismatches;
    assign pending_count = rsp_due_q.size();

    task automatic deque_apply(input pdq_pkg::pdq_req_t item,
                               output pdq_pkg::pdq_rsp_t res);
        int                                pos;
        int                                idx;
        logic signed [pdq_pkg::PRIO_W-1:0] key;
        res.status     = pdq_pkg::ST_OK;
        res.popped_tag = '0;
        case (item.op)
            pdq_pkg::OP_PUSH_FRONT, pdq_pkg::OP_PUSH_BACK:
            begin
                if (item.tag != '0)
                begin
                    if (fill >= pdq_pkg::DEPTH)
                    begin
                        res.status = pdq_pkg::ST_FULL;
                    end
                    else
                    begin
                        if (ordered_mode)
                        begin
                            // after the leading run of entries of equal or higher priority
                            key = $signed(item.priority_req);
                            pos = 0;
                            while (pos < fill && prio_cell[pos] >= key)
                                pos++;
                        end
                        else
                        begin
                            key = '0;
                            pos = (item.op == pdq_pkg::OP_PUSH_FRONT) ? 0 : fill;
                        end
                        for (idx = fill; idx > pos; idx--)
                        begin
                            tag_cell[idx]  = tag_cell[idx-1];
                            prio_cell[idx] = prio_cell[idx-1];
                        end
                        tag_cell[pos]  = item.tag;
                        prio_cell[pos] = key;
                        fill++;
                    end
                end
            end
            pdq_pkg::OP_POP_FRONT:
            begin
                if (fill == 0)
                begin
                    res.status = pdq_pkg::ST_EMPTY;
                end
                else
                begin
                    res.popped_tag = tag_cell[0];
                    for (idx = 1; idx < fill; idx++)
                    begin
                        tag_cell[idx-1]  = tag_cell[idx];
                        prio_cell[idx-1] = prio_cell[idx];
                    end
                    fill--;
                end
            end
            pdq_pkg::OP_POP_BACK:
            begin
                if (fill == 0)
                begin
                    res.status = pdq_pkg::ST_EMPTY;
                end
                else
                begin
                    res.popped_tag = tag_cell[fill-1];
                    fill--;
                end
            end
            pdq_pkg::OP_CLEAR:
            begin
                fill = 0;
            end
            default:
            begin
            end
        endcase
        res.entry_count = 5'(fill);
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fill         = 0;
            ordered_mode = 1'b0;
            rsp_due_q.delete();
        end
        else
        begin
            // result strobe belongs to an earlier item: check before predicting
            if (done)
            begin
                results_seen++;
                if (rsp_due_q.size() == 0)
                begin
                    mismatches++;
                    if (mismatches <= REPORT_MAX)
                        $display("ERROR: result %0d with no item outstanding:",
                                 results_seen,
                                 " status=%0d tag=%h count=%0d",
                                 rsp.status, rsp.popped_tag, rsp.entry_count);
                end
                else
                begin
                    want = rsp_due_q.pop_front();
                    if (rsp.status !== want.status || rsp.popped_tag !== want.popped_tag ||
                        rsp.entry_count !== want.entry_count)
                    begin
                        mismatches++;
                        if (mismatches <= REPORT_MAX)
                            $display("ERROR: result %0d: expected status=%0d tag=%h",
                                     results_seen, want.status, want.popped_tag,
                                     " count=%0d, got status=%0d tag=%h count=%0d",
                                     want.entry_count, rsp.status, rsp.popped_tag,
                                     rsp.entry_count);
                    end
                end
            end
            if (start && !busy)
            begin
                deque_apply(req, predicted);
                rsp_due_q.insert(rsp_due_q.size(), predicted);
            end
            if (cfg_we)
                ordered_mode = cfg_wdata;
        end
    end

endmodule
`default_nettype wire

>>> verif/testbench.sv
`default_nettype none
// ----------------------------------------------------------------------------
// testbench
// Stimulus and verdict for priority_deque_unit. A directed pass walks the
// edge cases in both modes, then random phases alternate the mode register
// and vary the push/pop mix, priority spread and idle gaps. A checker
// instance beside the block predicts and compares every result.
// ----------------------------------------------------------------------------
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    // Op codes 5..7 are not decoded; the block answers them as no-ops
    localparam logic [2:0] OP_RSVD_FIRST = 3'd5;
    localparam logic [2:0] OP_RSVD_LAST  = 3'd7;

    localparam int TAG_W  = pdq_pkg::TAG_W;
    localparam int PRIO_W = pdq_pkg::PRIO_W;

    localparam int RESET_CYCLES  = 9;
    localparam int DRAIN_CYCLES  = 4;      // margin past the last result strobe
    localparam int CYCLE_LIMIT   = 200000; // far above the slowest legal run
    localparam int PHASES        = 8;
    localparam int ITEMS_PER_PHASE = 50;

    logic              clk       = 1'b0;
    logic              rst_n     = 1'b0;
    logic              start     = 1'b0;
    logic              busy;
    pdq_pkg::pdq_req_t req       = '0;
    logic              done;
    pdq_pkg::pdq_rsp_t rsp;
    logic              cfg_we    = 1'b0;
    logic              cfg_wdata = 1'b0;

    int fail_count;
    int pending_count;
    int cycle_count   = 0;
    int items_sent    = 0;
    int mode_writes   = 0;
    int directed_sent = 0;

    // 10 ns clock
    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    priority_deque_unit i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .busy      (busy),
        .req       (req),
        .done      (done),
        .rsp       (rsp),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata)
    );

    pdq_checker i_checker (
        .clk           (clk),
        .rst_n         (rst_n),
        .start         (start),
        .busy          (busy),
        .req           (req),
        .done          (done),
        .rsp           (rsp),
        .cfg_we        (cfg_we),
        .cfg_wdata     (cfg_wdata),
        .fail_count    (fail_count),
        .pending_count (pending_count)
    );

    // Watchdog: a hung handshake or a lost result ends up here
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    // Drive one item from a falling edge, hold it until the block takes it,
    // then idle for gap cycles. Returns on a falling edge with start still
    // high when gap is 0, so back-to-back items keep start asserted.
    task automatic run_op(input logic [2:0] op, input logic [TAG_W-1:0] tag,
                          input logic signed [PRIO_W-1:0] prio, input int gap);
        pdq_pkg::pdq_req_t item;
        item.op           = op;
        item.tag          = tag;
        item.priority_req = prio;
        start <= 1'b1;
        req   <= item;
        @(posedge clk);
        while (busy)
            @(posedge clk);
        @(negedge clk);
        items_sent++;
        if (gap > 0)
        begin
            start <= 1'b0;
            repeat (gap) @(negedge clk);
        end
    endtask

    // Stop sending and wait until every outstanding item has answered
    task automatic settle();
        start <= 1'b0;
        @(negedge clk);
        while (pending_count != 0)
            @(negedge clk);
        repeat (DRAIN_CYCLES) @(negedge clk);
    endtask

    // Mode register is only touched with the block idle
    task automatic write_mode(input logic value);
        settle();
        cfg_we    <= 1'b1;
        cfg_wdata <= value;
        @(negedge clk);
        cfg_we    <= 1'b0;
        @(negedge clk);
        mode_writes++;
    endtask

    // Mostly back-to-back, some short gaps, a few long ones
    function automatic int pick_gap(input bit idle_on);
        int r;
        if (!idle_on)
            return 0;
        r = $urandom_range(99);
        if (r < 60)
            return 0;
        else if (r < 92)
            return $urandom_range(3, 1);
        else
            return $urandom_range(40, 10);
    endfunction

    function automatic logic [2:0] pick_op(input int push_pct);
        int r;
        r = $urandom_range(99);
        if (r < push_pct)
            return $urandom_range(1) ? pdq_pkg::OP_PUSH_BACK : pdq_pkg::OP_PUSH_FRONT;
        else if (r < 95)
            return $urandom_range(1) ? pdq_pkg::OP_POP_BACK : pdq_pkg::OP_POP_FRONT;
        else if (r < 98)
            return pdq_pkg::OP_CLEAR;
        else
            return 3'($urandom_range(OP_RSVD_LAST, OP_RSVD_FIRST));
    endfunction

    // Null tag now and then, all-ones now and then, else anything
    function automatic logic [TAG_W-1:0] pick_tag();
        case ($urandom_range(15))
            0:       return '0;
            1:       return '1;
            default: return TAG_W'($urandom);
        endcase
    endfunction

    // style 0: narrow band for lots of ties, 1: full range, 2: extremes
    function automatic logic signed [PRIO_W-1:0] pick_prio(input int style);
        case (style)
            0:
                return PRIO_W'(int'($urandom_range(6)) - 3);
            1:
                return PRIO_W'($urandom);
            default:
            begin
                case ($urandom_range(4))
                    0:       return {1'b1, {(PRIO_W-1){1'b0}}};
                    1:       return {1'b0, {(PRIO_W-1){1'b1}}};
                    2:       return '0;
                    3:       return '1;
                    default: return PRIO_W'(1);
                endcase
            end
        endcase
    endfunction

    initial
    begin
        int phase;
        int k;
        int push_pct;
        int prio_style;
        bit idle_on;

        repeat (RESET_CYCLES) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // ---------------- directed: deque mode straight out of reset ----------
        run_op(pdq_pkg::OP_POP_FRONT,  '0, '0, 0);            // pop front on empty
        run_op(pdq_pkg::OP_POP_BACK,   '0, '0, 1);            // pop back on empty
        run_op(pdq_pkg::OP_PUSH_FRONT, '0, 16'sh1234, 0);     // null tag is dropped
        run_op(pdq_pkg::OP_PUSH_BACK,  32'h0000_0001, 16'sh7FFF, 0); // priority ignored
        run_op(pdq_pkg::OP_PUSH_FRONT, 32'hFFFF_FFFF, 16'sh8000, 2);
        run_op(pdq_pkg::OP_PUSH_BACK,  32'hA5A5_A5A5, 16'sh0000, 0);
        run_op(OP_RSVD_FIRST, 32'hDEAD_BEEF, 16'sh5555, 0); // undecoded ops
        run_op(3'(OP_RSVD_FIRST + 3'd1), 32'h5A5A_5A5A, 16'shAAAA, 0);
        run_op(OP_RSVD_LAST,  32'hFFFF_FFFF, 16'shFFFF, 0);
        run_op(pdq_pkg::OP_POP_BACK,   '0, '0, 0);
        run_op(pdq_pkg::OP_POP_FRONT,  '0, '0, 3);
        run_op(pdq_pkg::OP_POP_BACK,   '0, '0, 0);            // last entry leaves the back
        run_op(pdq_pkg::OP_PUSH_BACK,  32'h1234_5678, 16'sh0001, 0); // head empty too
        run_op(pdq_pkg::OP_POP_FRONT,  '0, '0, 0);
        run_op(pdq_pkg::OP_PUSH_FRONT, 32'h0000_0055, 16'sh0000, 0);
        run_op(pdq_pkg::OP_CLEAR,      32'hFFFF_FFFF, 16'shFFFF, 0);
        run_op(pdq_pkg::OP_PUSH_BACK,  32'h0000_0077, 16'sh7FFF, 0); // stored as 0

        // ---------------- directed: priority mode over a deque entry ----------
        write_mode(1'b1);
        run_op(pdq_pkg::OP_PUSH_FRONT, 32'h0000_0100, 16'shFFFF, 0); // -1 behind 0
        run_op(pdq_pkg::OP_PUSH_BACK,  32'h0000_0101, 16'sh7FFF, 0); // max to the front
        run_op(pdq_pkg::OP_PUSH_FRONT, 32'h0000_0102, 16'sh8000, 1); // min to the back
        run_op(pdq_pkg::OP_PUSH_BACK,  32'h0000_0103, 16'sh0000, 0); // tie: after old 0
        run_op(pdq_pkg::OP_PUSH_FRONT, 32'h0000_0104, 16'sh7FFF, 0); // tie at the top
        run_op(pdq_pkg::OP_PUSH_FRONT, '0, 16'sh0005, 0);
        run_op(pdq_pkg::OP_POP_FRONT,  '0, '0, 0);
        run_op(pdq_pkg::OP_POP_BACK,   '0, '0, 0);
        run_op(pdq_pkg::OP_CLEAR,      '0, '0, 0);
        directed_sent = items_sent;

        // ---------------- random phases ----------------
        // The store is not cleared between phases, so each mode change
        // lands on content left by the other mode.
        for (phase = 0; phase < PHASES; phase++)
        begin
            write_mode((phase % 2 == 0) ? 1'b0 : 1'b1);
            // every third phase leans on pushes to reach and hold a full store
            push_pct   = (phase % 3 == 0) ? 85 : $urandom_range(70, 30);
            prio_style = $urandom_range(2);
            idle_on    = ($urandom_range(3) != 0);
            for (k = 0; k < ITEMS_PER_PHASE; k++)
            begin
                // occasional full drain mid-phase
                if ($urandom_range(39) == 0)
                    settle();
                run_op(pick_op(push_pct), pick_tag(), pick_prio(prio_style),
                       pick_gap(idle_on));
            end
        end

        settle();

        $display("Sent %0d items (%0d directed, %0d random in %0d phases), %0d mode writes.",
                 items_sent, directed_sent, items_sent - directed_sent, PHASES, mode_writes);
        $display("Both modes, full and empty store, null tags, clears and undecoded ops ran.");
        if (fail_count == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
`default_nettype wire
